FILE: rtl/irbf_pkg.sv
// Package for the IPv4 range block filter: commands, status codes, slot layout,
// sequencer states and the records passed between the scan unit and the top level.
// No dependencies.
`default_nettype none

package irbf_pkg;

   // Table depth default, handed to the top level parameter
   localparam int unsigned TABLE_ENTRIES_DEF = 64;

   // Field widths
   localparam int unsigned IP_W  = 32;
   localparam int unsigned ID_W  = 16;
   localparam int unsigned CMD_W = 2;
   localparam int unsigned ST_W  = 2;

   // Stream widths (fields packed from bit 0, zero filled to whole bytes)
   localparam int unsigned REQ_TDATA_W = 112;
   localparam int unsigned RSP_TDATA_W = 24;

   typedef enum logic [CMD_W-1:0] {
      CMD_CHECK  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_END  = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // One table slot as held in the memory
   typedef struct packed {
      logic            valid;
      logic [IP_W-1:0] low;
      logic [IP_W-1:0] high;
      logic [ID_W-1:0] ident;
   } slot_type;

   localparam int unsigned SLOT_W = $bits(slot_type);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FINISH
   } fsm_type;

   // Sequencer to scan unit
   typedef struct packed {
      logic start;   // new item: clear trackers
      logic rd_vld;  // read data of one slot is on the memory output
   } scan_ctl_type;

   // Scan unit to sequencer
   typedef struct packed {
      logic            any;         // some slot is valid
      logic            found;       // address lies in a stored range
      logic [ID_W-1:0] best_id;     // id of the hit with the lowest low end
      logic            free_found;  // a free slot exists
      logic            id_found;    // a valid slot holds entry_id
   } scan_res_type;

endpackage : irbf_pkg

`default_nettype wire

FILE: rtl/irbf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the slot table. No dependencies.
`default_nettype none

module irbf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : irbf_ram

`default_nettype wire

FILE: rtl/irbf_scan.sv
// Scan unit: walks the slot words coming out of the table memory and keeps the
// trackers for a lookup (best hit), a free slot and an id search. Uses irbf_pkg.
`default_nettype none

module irbf_scan
   import irbf_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int unsigned AW            = $clog2(TABLE_ENTRIES)
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire scan_ctl_type    ctl,
   input  wire logic [AW-1:0]   rd_idx,
   input  wire slot_type        rd_word,
   input  wire logic [IP_W-1:0] address,
   input  wire logic [ID_W-1:0] entry_id,
   output scan_res_type         res,
   output logic      [AW-1:0]   free_idx,
   output logic      [AW-1:0]   id_idx
);

   logic            any_ff,        any_in;
   logic            found_ff,      found_in;
   logic [IP_W-1:0] best_low_ff,   best_low_in;
   logic [ID_W-1:0] best_id_ff,    best_id_in;
   logic            free_found_ff, free_found_in;
   logic [AW-1:0]   free_idx_ff,   free_idx_in;
   logic            id_found_ff,   id_found_in;
   logic [AW-1:0]   id_idx_ff,     id_idx_in;

   logic hit;
   logic better;
   logic id_hit;

   // Per-slot tests
   assign hit    = rd_word.valid && (address >= rd_word.low) && (address <= rd_word.high);
   assign better = !found_ff || (rd_word.low < best_low_ff);
   assign id_hit = rd_word.valid && (rd_word.ident == entry_id);

   // Tracker updates; slots arrive in ascending order, so first match wins ties
   always_comb begin
      any_in        = any_ff;
      found_in      = found_ff;
      best_low_in   = best_low_ff;
      best_id_in    = best_id_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      id_found_in   = id_found_ff;
      id_idx_in     = id_idx_ff;
      if (ctl.start) begin
         any_in        = 1'b0;
         found_in      = 1'b0;
         free_found_in = 1'b0;
         id_found_in   = 1'b0;
      end else if (ctl.rd_vld) begin
         if (rd_word.valid) begin
            any_in = 1'b1;
         end
         if (hit && better) begin
            found_in    = 1'b1;
            best_low_in = rd_word.low;
            best_id_in  = rd_word.ident;
         end
         if (!rd_word.valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx;
         end
         if (id_hit && !id_found_ff) begin
            id_found_in = 1'b1;
            id_idx_in   = rd_idx;
         end
      end
   end

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff        <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         id_found_ff   <= 1'b0;
      end else begin
         any_ff        <= any_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         id_found_ff   <= id_found_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      best_low_ff <= best_low_in;
      best_id_ff  <= best_id_in;
      free_idx_ff <= free_idx_in;
      id_idx_ff   <= id_idx_in;
   end

   assign res.any        = any_ff;
   assign res.found      = found_ff;
   assign res.best_id    = best_id_ff;
   assign res.free_found = free_found_ff;
   assign res.id_found   = id_found_ff;
   assign free_idx       = free_idx_ff;
   assign id_idx         = id_idx_ff;

endmodule : irbf_scan

`default_nettype wire

FILE: rtl/ip_range_block_filter.sv
// Channel  | Ports                          | Item contents
// ---------+--------------------------------+-------------------------------------------
// request  | req_tvalid/tready/tdata/tuser  | tuser: command; tdata: address, range ends,
//          |                                | entry_id
// response | rsp_tvalid/tready/tdata        | blocked, in_range, match_id, status
// csr      | csr_we/csr_wdata               | default_block
//
// For each item the sequencer reads every slot of the table memory once through its
// single read port, then writes back at most one slot. After reset a clearing pass
// zeroes the table; req_tready stays low meanwhile. The next item is accepted while
// a result still waits in the output register; a finished item waits only if that
// register is still full.
// Top level of the IPv4 range block filter. Uses irbf_pkg, irbf_ram and irbf_scan.
`default_nettype none

module ip_range_block_filter
   import irbf_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request: tdata = address[31:0], range_first[63:32], range_last[95:64],
   //          entry_id[111:96]; tuser = command[1:0]
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [CMD_W-1:0]       req_tuser,
   // response: tdata = blocked[0], in_range[1], match_id[17:2], status[19:18],
   //           zeros[23:20]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   // configuration
   input  wire logic                   csr_we,
   input  wire logic                   csr_wdata
);

   localparam int unsigned AW = $clog2(TABLE_ENTRIES);
   localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

   // Sequencer and item registers
   fsm_type         state_ff,   state_in;
   logic [CW-1:0]   cnt_ff,     cnt_in;
   cmd_type         cmd_ff;
   logic [IP_W-1:0] addr_ff;
   logic [IP_W-1:0] lo_ff;
   logic [IP_W-1:0] hi_ff;
   logic            zero_end_ff;
   logic [ID_W-1:0] entry_id_ff;
   logic [ID_W-1:0] id_ctr_ff,  id_ctr_in;
   logic            default_block_ff;
   logic            rd_vld_ff;
   logic [AW-1:0]   rd_idx_ff;

   // Output register
   logic            rsp_valid_ff;
   logic            blocked_ff,  blocked_in;
   logic            in_range_ff, in_range_in;
   logic [ID_W-1:0] match_id_ff, match_id_in;
   status_type      status_ff,   status_in;

   // Request fields
   logic [IP_W-1:0] req_address;
   logic [IP_W-1:0] req_first;
   logic [IP_W-1:0] req_last;
   logic [ID_W-1:0] req_entry_id;

   logic            accept;
   logic            rsp_free;
   logic            finish;
   logic            cnt_last;
   logic            cnt_end;

   // Memory ports
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   slot_type        mem_wword;
   logic            mem_re;
   logic [SLOT_W-1:0] mem_rdata;
   slot_type        rd_word;

   scan_ctl_type    scan_ctl;
   scan_res_type    scan_res;
   logic [AW-1:0]   free_idx;
   logic [AW-1:0]   id_idx;

   assign req_address  = req_tdata[31:0];
   assign req_first    = req_tdata[63:32];
   assign req_last     = req_tdata[95:64];
   assign req_entry_id = req_tdata[111:96];

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign finish   = (state_ff == S_FINISH) && rsp_free;
   assign cnt_last = (cnt_ff == CW'(TABLE_ENTRIES - 1));
   assign cnt_end  = (cnt_ff == CW'(TABLE_ENTRIES));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (cnt_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (cnt_end) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Slot counter: clearing pass and scan
   always_comb begin
      cnt_in = cnt_ff;
      unique case (state_ff)
         S_CLEAR:  cnt_in = cnt_last ? '0 : cnt_ff + CW'(1);
         S_IDLE:   cnt_in = '0;
         S_SCAN:   cnt_in = cnt_end ? cnt_ff : cnt_ff + CW'(1);
         S_FINISH: cnt_in = '0;
         default:  cnt_in = '0;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready       = (state_ff == S_IDLE);
      mem_re           = (state_ff == S_SCAN) && !cnt_end;
      scan_ctl.start   = accept;
      scan_ctl.rd_vld  = rd_vld_ff;
   end

   // Clearing writes in S_CLEAR; write-back and result, taken when the item leaves S_FINISH
   always_comb begin
      mem_we      = 1'b0;
      mem_waddr   = cnt_ff[AW-1:0];
      mem_wword   = '0;
      id_ctr_in   = id_ctr_ff;
      blocked_in  = 1'b0;
      in_range_in = 1'b0;
      match_id_in = '0;
      status_in   = ST_OK;
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == S_FINISH) begin
         unique case (cmd_ff)
            CMD_CHECK: begin
               if ((addr_ff != '0) && scan_res.any) begin
                  in_range_in = scan_res.found;
                  blocked_in  = scan_res.found ? !default_block_ff : default_block_ff;
                  match_id_in = scan_res.found ? scan_res.best_id : '0;
               end
            end
            CMD_ADD: begin
               if (zero_end_ff) begin
                  status_in = ST_ZERO_END;
               end else if (!scan_res.free_found) begin
                  status_in = ST_FULL;
               end else begin
                  id_ctr_in       = id_ctr_ff + ID_W'(1);
                  match_id_in     = id_ctr_in;
                  mem_we          = finish;
                  mem_waddr       = free_idx;
                  mem_wword.valid = 1'b1;
                  mem_wword.low   = lo_ff;
                  mem_wword.high  = hi_ff;
                  mem_wword.ident = id_ctr_in;
               end
            end
            CMD_UPDATE: begin
               match_id_in = entry_id_ff;
               if (zero_end_ff) begin
                  status_in = ST_ZERO_END;
               end else if (!scan_res.id_found) begin
                  status_in = ST_NOT_FOUND;
               end else begin
                  mem_we          = finish;
                  mem_waddr       = id_idx;
                  mem_wword.valid = 1'b1;
                  mem_wword.low   = lo_ff;
                  mem_wword.high  = hi_ff;
                  mem_wword.ident = entry_id_ff;
               end
            end
            CMD_REMOVE: begin
               match_id_in = entry_id_ff;
               if (!scan_res.id_found) begin
                  status_in = ST_NOT_FOUND;
               end else begin
                  mem_we    = finish;
                  mem_waddr = id_idx;
               end
            end
            default: status_in = ST_OK;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         cnt_ff           <= '0;
         id_ctr_ff        <= '0;
         default_block_ff <= 1'b0;
         rd_vld_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= mem_re;
         if (finish) begin
            id_ctr_ff <= id_ctr_in;
         end
         if (csr_we) begin
            default_block_ff <= csr_wdata;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item and result payload
   always_ff @(posedge clock) begin
      rd_idx_ff <= cnt_ff[AW-1:0];
      if (accept) begin
         cmd_ff      <= cmd_type'(req_tuser);
         addr_ff     <= req_address;
         lo_ff       <= (req_first < req_last) ? req_first : req_last;
         hi_ff       <= (req_first < req_last) ? req_last : req_first;
         zero_end_ff <= (req_first == '0) || (req_last == '0);
         entry_id_ff <= req_entry_id;
      end
      if (finish) begin
         blocked_ff  <= blocked_in;
         in_range_ff <= in_range_in;
         match_id_ff <= match_id_in;
         status_ff   <= status_in;
      end
   end

   // Slot table
   irbf_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_ENTRIES),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wword),
      .rd_en   (mem_re),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (mem_rdata)
   );

   assign rd_word = slot_type'(mem_rdata);

   // Scan trackers
   irbf_scan #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .AW            (AW)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .rd_idx   (rd_idx_ff),
      .rd_word  (rd_word),
      .address  (addr_ff),
      .entry_id (entry_id_ff),
      .res      (scan_res),
      .free_idx (free_idx),
      .id_idx   (id_idx)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, status_ff, match_id_ff, in_range_ff, blocked_ff};

endmodule : ip_range_block_filter

`default_nettype wire

FILE: tb/sv/tb_ip_range_block_filter.sv
// Self-checking testbench for ip_range_block_filter: streams ACL commands, predicts each verdict
// from its own copy of the range table and compares every response field.
// Depends on irbf_pkg and the ip_range_block_filter RTL.
`default_nettype none

module tb_ip_range_block_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import irbf_pkg::*;

   localparam int TABLE_DEPTH = TABLE_ENTRIES_DEF;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      cmd_type         cmd;
      logic [IP_W-1:0] address;
      logic [IP_W-1:0] range_first;
      logic [IP_W-1:0] range_last;
      logic [ID_W-1:0] entry_id;
   } acl_cmd_item;

   typedef struct {
      logic            blocked;
      logic            in_range;
      logic [ID_W-1:0] match_id;
      status_type      status;
   } acl_verdict;

   // DUT signals; the inputs are all known from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]       req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic                   csr_wdata = 1'b0;

   // Predicted table contents and policy
   logic            tbl_valid [TABLE_DEPTH];
   logic [IP_W-1:0] tbl_low   [TABLE_DEPTH];
   logic [IP_W-1:0] tbl_high  [TABLE_DEPTH];
   logic [ID_W-1:0] tbl_ident [TABLE_DEPTH];
   logic [ID_W-1:0] last_issued_id = '0;
   logic            dflt_block = 1'b0;

   acl_cmd_item pending_cmds[$];
   acl_verdict  expected_verdicts[$];
   acl_cmd_item on_bus;

   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  hold_left = 0;
   bit  req_taken = 1'b0;
   int  errors = 0;
   int  cycles = 0;
   int  n_accepted = 0;
   int  n_verdicts = 0;
   int  n_hits = 0;
   int  n_full = 0;
   int  n_not_found = 0;
   int  n_zero_end = 0;

   ip_range_block_filter #(
      .TABLE_ENTRIES(TABLE_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // address, range_first, range_last, entry_id
      .req_tuser  (req_tuser),   // command
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // blocked, in_range, match_id, status, zero fill
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_low[i]   = '0;
         tbl_high[i]  = '0;
         tbl_ident[i] = '0;
      end
   end

   // Apply one command to the predicted table and return the verdict it gives
   function automatic acl_verdict apply_acl_cmd(acl_cmd_item c);
      acl_verdict      v;
      logic [IP_W-1:0] lo;
      logic [IP_W-1:0] hi;
      int              best;
      int              slot;
      bit              any_live;
      v.blocked  = 1'b0;
      v.in_range = 1'b0;
      v.match_id = '0;
      v.status   = ST_OK;
      lo = (c.range_first < c.range_last) ? c.range_first : c.range_last;
      hi = (c.range_first < c.range_last) ? c.range_last : c.range_first;
      best = -1;
      slot = -1;
      any_live = 1'b0;
      case (c.cmd)
         CMD_CHECK: begin
            if (c.address != '0) begin
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (tbl_valid[i]) begin
                     any_live = 1'b1;
                     // strict compare keeps the lowest slot on equal low ends
                     if (c.address >= tbl_low[i] && c.address <= tbl_high[i] &&
                         (best < 0 || tbl_low[i] < tbl_low[best]))
                        best = i;
                  end
               end
               if (best >= 0) begin
                  v.in_range = 1'b1;
                  v.blocked  = !dflt_block;
                  v.match_id = tbl_ident[best];
               end else if (any_live) begin
                  v.blocked = dflt_block;
               end
            end
         end
         CMD_ADD: begin
            if (c.range_first == '0 || c.range_last == '0) begin
               v.status = ST_ZERO_END;
            end else begin
               for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                  if (!tbl_valid[i]) slot = i;
               if (slot < 0) begin
                  v.status = ST_FULL;
               end else begin
                  last_issued_id  = last_issued_id + 1'b1;
                  tbl_valid[slot] = 1'b1;
                  tbl_low[slot]   = lo;
                  tbl_high[slot]  = hi;
                  tbl_ident[slot] = last_issued_id;
                  v.match_id      = last_issued_id;
               end
            end
         end
         default: begin
            // update and remove both act on the lowest slot holding the id
            v.match_id = c.entry_id;
            for (int i = TABLE_DEPTH - 1; i >= 0; i--)
               if (tbl_valid[i] && tbl_ident[i] == c.entry_id) slot = i;
            if (c.cmd == CMD_UPDATE && (c.range_first == '0 || c.range_last == '0)) begin
               v.status = ST_ZERO_END;
            end else if (slot < 0) begin
               v.status = ST_NOT_FOUND;
            end else if (c.cmd == CMD_UPDATE) begin
               tbl_low[slot]  = lo;
               tbl_high[slot] = hi;
            end else begin
               tbl_valid[slot] = 1'b0;
            end
         end
      endcase
      return v;
   endfunction

   // Random command, mostly aimed at ranges and ids that are currently stored
   function automatic acl_cmd_item make_cmd(int add_w, int upd_w, int rem_w);
      acl_cmd_item     c;
      int              live[$];
      int              s;
      int              roll;
      logic [IP_W-1:0] a;
      logic [IP_W-1:0] b;
      logic [IP_W-1:0] base;
      logic [IP_W:0]   span;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (tbl_valid[i]) live.push_back(i);
      s = (live.size() > 0) ? live[$urandom_range(live.size() - 1)] : -1;

      // range ends: clustered, wild, zero, extreme or copied from a stored entry
      roll = $urandom_range(99);
      if (roll < 55) begin
         base = 32'h0A00_0000 | $urandom_range(0, 4095);
         a = base;
         b = base + $urandom_range(0, 600);
      end else if (roll < 70 || (roll >= 90 && s < 0)) begin
         a = $urandom;
         b = $urandom;
      end else if (roll < 80) begin
         a = '0;
         b = $urandom_range(1) ? '0 : ($urandom | 32'd1);
      end else if (roll < 90) begin
         a = $urandom_range(1) ? 32'd1 : $urandom;
         b = '1;
      end else begin
         a = tbl_low[s];
         b = tbl_high[s];
      end
      c.range_first = $urandom_range(1) ? a : b;
      c.range_last  = (c.range_first == a) ? b : a;
      c.entry_id = (s >= 0 && $urandom_range(99) < 85) ? tbl_ident[s] : ID_W'($urandom);

      // address for checks
      roll = $urandom_range(99);
      if (roll < 5) begin
         c.address = '0;
      end else if (roll < 55 && s >= 0) begin
         span = {1'b0, tbl_high[s]} - {1'b0, tbl_low[s]} + 33'd1;
         c.address = tbl_low[s] + IP_W'({1'b0, $urandom} % span);
      end else if (roll < 70 && s >= 0) begin
         c.address = $urandom_range(1) ? tbl_low[s] - 1'b1 : tbl_high[s] + 1'b1;
      end else if (roll < 80) begin
         c.address = 32'h0A00_0000 | $urandom_range(0, 5000);
      end else begin
         c.address = $urandom_range(9) == 0 ? '1 : $urandom;
      end

      roll = $urandom_range(99);
      if (roll < add_w)                      c.cmd = CMD_ADD;
      else if (roll < add_w + upd_w)         c.cmd = CMD_UPDATE;
      else if (roll < add_w + upd_w + rem_w) c.cmd = CMD_REMOVE;
      else                                   c.cmd = CMD_CHECK;
      return c;
   endfunction

   task automatic push_cmd(cmd_type cmd, logic [IP_W-1:0] address, logic [IP_W-1:0] first,
                           logic [IP_W-1:0] last, logic [ID_W-1:0] id);
      acl_cmd_item c;
      c.cmd = cmd;
      c.address = address;
      c.range_first = first;
      c.range_last = last;
      c.entry_id = id;
      pending_cmds.push_back(c);
   endtask

   // Block until every queued item is accepted and every verdict has returned
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_cmds.size() != 0 || req_tvalid || expected_verdicts.size() != 0);
   endtask

   // One phase: policy write while idle, then random traffic under the given idling
   task automatic run_phase(bit block_outside, int idle_pct, int stall_pct, int hold,
                            int n, int add_w, int upd_w, int rem_w);
      int made;
      wait_drained();
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= block_outside;
      @(negedge clock);
      csr_we     <= 1'b0;
      dflt_block = block_outside;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (hold > 0) begin
         @(posedge clock);
         hold_left = hold;
      end
      made = 0;
      while (made < n) begin
         if (pending_cmds.size() < 2) begin
            pending_cmds.push_back(make_cmd(add_w, upd_w, rem_w));
            made++;
         end else begin
            @(negedge clock);
         end
      end
   endtask

   // Request driver: next item goes out on the falling edge once the last one was taken
   always @(negedge clock) begin : drive_req
      bit offer;
      offer = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            on_bus = pending_cmds.pop_front();
            offer  = 1'b1;
            req_tdata <= {on_bus.entry_id, on_bus.range_last, on_bus.range_first,
                          on_bus.address};
            req_tuser <= on_bus.cmd;
         end
         req_tvalid <= offer;
      end
   end

   // Response back-pressure; a pending hold-off is counted down here
   always @(negedge clock) begin : drive_rsp
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Sample both channels on the rising edge: predict on accept, compare on response
   always @(posedge clock) begin : score_bus
      acl_verdict want;
      acl_verdict got;
      req_taken <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         expected_verdicts.push_back(apply_acl_cmd(on_bus));
         n_accepted++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.blocked  = rsp_tdata[0];
         got.in_range = rsp_tdata[1];
         got.match_id = rsp_tdata[17:2];
         got.status   = status_type'(rsp_tdata[19:18]);
         if (expected_verdicts.size() == 0) begin
            $error("unexpected response item, tdata %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_verdicts.pop_front();
            n_verdicts++;
            if (want.in_range) n_hits++;
            if (want.status == ST_FULL) n_full++;
            if (want.status == ST_NOT_FOUND) n_not_found++;
            if (want.status == ST_ZERO_END) n_zero_end++;
            if (got.blocked !== want.blocked) begin
               $error("blocked: expected %0d, got %0d", want.blocked, got.blocked);
               errors++;
            end
            if (got.in_range !== want.in_range) begin
               $error("in_range: expected %0d, got %0d", want.in_range, got.in_range);
               errors++;
            end
            if (got.match_id !== want.match_id) begin
               $error("match_id: expected %0d, got %0d", want.match_id, got.match_id);
               errors++;
            end
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               errors++;
            end
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d verdicts still owed", cycles,
               expected_verdicts.size());
      $display("status: fail");
      $finish;
   end

   // Stimulus
   initial begin : stimulus
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, bad ends, ordering, overlaps, tie on low end
      push_cmd(CMD_CHECK,  32'h0102_0304, '0, '0, '0);
      push_cmd(CMD_REMOVE, '0, '0, '0, 16'd5);
      push_cmd(CMD_UPDATE, '0, 32'd10, 32'd20, 16'd1);
      push_cmd(CMD_ADD,    '0, '0, 32'h0A00_0005, '0);
      push_cmd(CMD_ADD,    '0, 32'h0A00_0005, '0, '0);
      push_cmd(CMD_ADD,    '0, 32'h0A00_0064, 32'h0A00_0001, '0);
      push_cmd(CMD_ADD,    '0, 32'h0A00_0050, 32'h0A00_0080, '0);
      push_cmd(CMD_ADD,    '0, 32'h0A00_0001, 32'h0A00_0020, '0);
      push_cmd(CMD_CHECK,  32'h0A00_0060, '0, '0, '0);
      push_cmd(CMD_CHECK,  32'h0A00_0010, '0, '0, '0);
      push_cmd(CMD_CHECK,  32'h0A00_0070, '0, '0, '0);
      push_cmd(CMD_CHECK,  '0, '0, '0, '0);
      push_cmd(CMD_CHECK,  32'hFFFF_FFFF, '0, '0, '0);
      push_cmd(CMD_UPDATE, '0, '0, 32'h0A00_0002, 16'd1);
      push_cmd(CMD_UPDATE, '0, 32'hFFFF_FFFF, 32'hC0A8_0000, 16'd1);
      push_cmd(CMD_CHECK,  32'hFFFF_FFFF, '0, '0, '0);
      push_cmd(CMD_ADD,    '0, 32'h0000_0001, 32'hFFFF_FFFF, '0);
      push_cmd(CMD_CHECK,  32'h0A00_0010, '0, '0, '0);
      push_cmd(CMD_REMOVE, '0, '0, '0, 16'd3);
      push_cmd(CMD_REMOVE, '0, '0, '0, 16'd3);
      push_cmd(CMD_CHECK,  32'h0A00_0010, '0, '0, '0);
      push_cmd(CMD_UPDATE, '0, 32'd1, 32'd2, 16'hFFFF);
      push_cmd(CMD_ADD,    '0, 32'h8000_0000, 32'h8000_0000, '0);
      push_cmd(CMD_CHECK,  32'h8000_0000, '0, '0, '0);

      // random phases: policy, sender idle %, receiver stall %, hold-off, items, mix
      run_phase(1'b1, 65,  0,   0, 200, 60, 10,  5);   // fills the table to full
      run_phase(1'b0,  0, 65, 400, 210, 25, 15, 20);   // long receiver hold-off first
      run_phase(1'b1, 23, 23,   0, 200, 10, 10, 50);   // drains to an empty table
      run_phase(1'b0,  0,  0,   0, 218, 30, 15, 20);

      wait_drained();
      repeat (TABLE_DEPTH + 8) @(posedge clock);

      $display("covered %0d items, %0d responses checked, %0d in-range hits",
               n_accepted, n_verdicts, n_hits);
      $display("table full %0d, id not found %0d, zero range end %0d, both policies",
               n_full, n_not_found, n_zero_end);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule : tb_ip_range_block_filter

`default_nettype wire

FILE: files.f
rtl/irbf_pkg.sv
rtl/irbf_ram.sv
rtl/irbf_scan.sv
rtl/ip_range_block_filter.sv
tb/sv/tb_ip_range_block_filter.sv
